>>> sv/in_order_release_buffer_top_assert.svh
// -----------------------------------------------------------------------------
// in-order release buffer assertion macros
// concurrent check wrappers, empty when built for synthesis
// -----------------------------------------------------------------------------
`ifndef IN_ORDER_RELEASE_BUFFER_TOP_ASSERT_SVH
`define IN_ORDER_RELEASE_BUFFER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// check gated off while reset is asserted
`define IORB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds across reset
`define IORB_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IORB_ASSERT(label, clk, rst_n, prop, msg)
`define IORB_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

>>> sv/iorb_pkg.sv
// -----------------------------------------------------------------------------
// in-order release buffer package
// transfer types, status and opcode codes, slot word and sequencer states
// -----------------------------------------------------------------------------
package iorb_pkg;

    // request opcodes
    localparam logic OP_ALLOC    = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        STAT_ALLOC   = 2'd0,
        STAT_DELIVER = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_BADID   = 2'd3
    } t_status;

    // input transfer
    typedef struct packed {
        logic        opcode;
        logic [15:0] seq_id;
        logic        has_receiver;
        logic [15:0] receiver_handle;
        logic [31:0] content_handle;
    } t_in;

    // output transfer
    typedef struct packed {
        t_status     status;
        logic [15:0] out_seq_id;
        logic [15:0] out_receiver;
        logic [31:0] out_content;
        logic        last;
    } t_out;

    // one reorder slot as held in memory
    typedef struct packed {
        logic        valid;
        logic        has_receiver;
        logic [15:0] receiver;
        logic [31:0] content;
    } t_slot;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_CHECK,
        ST_WALK_RD,
        ST_WALK_EX,
        ST_FLUSH
    } t_state;

endpackage

>>> sv/iorb_ram.sv
// -----------------------------------------------------------------------------
// generic simple dual-port ram
// one write port, one read port with registered read data
// -----------------------------------------------------------------------------
module iorb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/in_order_release_buffer_top.sv
// -----------------------------------------------------------------------------
// in-order release buffer
// reorder buffer that hands out sequence ids and releases completions in order
// -----------------------------------------------------------------------------
// usage
// - input channel i_in_valid / o_in_stall / i_in carries allocate and complete
//   requests; output channel o_out_valid / i_out_stall / o_out carries results,
//   the last result of a request flagged by last
// - one request at a time: o_in_stall is high from acceptance until the
//   request is done and its final result, if any, is in the output register
// - allocate or out-of-window id: the result is registered into the output
//   register once it is free; a store or duplicate id first reads its slot
// - a release walks the slot memory slot by slot (read, then examine and
//   clear) until an empty slot or the last outstanding id, then flushes;
//   the registered read of the slot memory sets the read and examine split
// - deliveries are held one deep so the final one can carry last
// - the output register holds a result while the receiver stalls, and the
//   next request may be accepted meanwhile; a stalled receiver pauses the walk
// - after reset a clearing pass zeroes every slot of the slot memory with
//   o_in_stall high; ids restart at zero
// -----------------------------------------------------------------------------
module in_order_release_buffer_top
    import iorb_pkg::*;
#(
    parameter int WINDOW  = 16,
    parameter int ID_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

`include "in_order_release_buffer_top_assert.svh"

    localparam int SLOT_BITS = $clog2(WINDOW);
    localparam int CNT_BITS  = $clog2(WINDOW + 1);
    localparam int CMP_BITS  = (ID_BITS > 17) ? ID_BITS : 17;
    localparam int SLOT_W    = $bits(t_slot);
    localparam logic [CMP_BITS-1:0]  WINDOW_C  = CMP_BITS'(WINDOW);
    localparam logic [SLOT_BITS:0]   WINDOW_S  = (SLOT_BITS + 1)'(WINDOW);
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(WINDOW - 1);

    t_state               r_state, n_state;
    t_in                  r_item, n_item;
    logic [ID_BITS-1:0]   r_next_id, n_next_id;
    logic [ID_BITS-1:0]   r_oldest_id, n_oldest_id;
    logic [SLOT_BITS-1:0] r_head, n_head;
    logic [SLOT_BITS-1:0] r_slot, n_slot;
    logic [CNT_BITS-1:0]  r_released, n_released;
    t_out                 r_pend, n_pend;
    logic                 r_pend_valid, n_pend_valid;
    t_out                 r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    logic                 ram_we, ram_re;
    logic [SLOT_BITS-1:0] ram_waddr, ram_raddr;
    t_slot                ram_wdata;
    logic [SLOT_W-1:0]    ram_rdata;
    t_slot                rd_slot;

    logic [ID_BITS-1:0]   req_id, outstanding, offset, walk_id;
    logic [CMP_BITS-1:0]  out_cmp, off_cmp, rel_cmp;
    logic                 win_full, bad_id, out_free, walk_more, walk_hold;
    logic [SLOT_BITS:0]   slot_sum;
    logic [SLOT_BITS-1:0] tgt_slot, slot_inc, head_inc;

    // slot memory
    iorb_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (WINDOW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_slot = t_slot'(ram_rdata);

    // window arithmetic
    always_comb begin
        req_id      = ID_BITS'(r_item.seq_id);
        outstanding = r_next_id - r_oldest_id;
        offset      = req_id - r_oldest_id;
        walk_id     = r_oldest_id + ID_BITS'(r_released);
        out_cmp     = CMP_BITS'(outstanding);
        off_cmp     = CMP_BITS'(offset);
        rel_cmp     = CMP_BITS'(r_released);
        win_full    = (out_cmp >= WINDOW_C) || (&outstanding);
        bad_id      = off_cmp >= out_cmp;
        walk_more   = rel_cmp < out_cmp;
        out_free    = !r_out_valid || !i_out_stall;
        walk_hold   = rd_slot.has_receiver && r_pend_valid && !out_free;
    end

    // slot index arithmetic, modulo WINDOW
    always_comb begin
        slot_sum = {1'b0, r_head} + (SLOT_BITS + 1)'(offset);
        tgt_slot = (slot_sum >= WINDOW_S) ? SLOT_BITS'(slot_sum - WINDOW_S)
                                          : SLOT_BITS'(slot_sum);
        slot_inc = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
        head_inc = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_slot == LAST_SLOT) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (r_item.opcode == OP_ALLOC || bad_id) begin
                    if (out_free) n_state = ST_IDLE;
                end else if (offset != '0) begin
                    n_state = ST_CHECK;
                end else begin
                    n_state = ST_WALK_RD;
                end
            end
            ST_CHECK: begin
                if (!rd_slot.valid || out_free) n_state = ST_IDLE;
            end
            ST_WALK_RD: begin
                n_state = walk_more ? ST_WALK_EX : ST_FLUSH;
            end
            ST_WALK_EX: begin
                if (!rd_slot.valid) begin
                    n_state = ST_FLUSH;
                end else if (!walk_hold) begin
                    n_state = ST_WALK_RD;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid || out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_item       = r_item;
        n_next_id    = r_next_id;
        n_oldest_id  = r_oldest_id;
        n_head       = r_head;
        n_slot       = r_slot;
        n_released   = r_released;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        ram_we       = 1'b0;
        ram_waddr    = r_slot;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = r_slot;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                n_slot = slot_inc;
            end
            ST_IDLE: begin
                n_item = i_in;
            end
            ST_DECODE: begin
                if (r_item.opcode == OP_ALLOC) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        if (win_full) begin
                            n_out = '{status: STAT_FULL, out_seq_id: '0,
                                      out_receiver: '0, out_content: '0, last: 1'b1};
                        end else begin
                            n_out = '{status: STAT_ALLOC, out_seq_id: 16'(r_next_id),
                                      out_receiver: '0, out_content: '0, last: 1'b1};
                            n_next_id = r_next_id + 1'b1;
                        end
                    end
                end else if (bad_id) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out = '{status: STAT_BADID, out_seq_id: 16'(req_id),
                                  out_receiver: '0, out_content: '0, last: 1'b1};
                    end
                end else if (offset != '0) begin
                    // look up the target slot for a duplicate
                    ram_re    = 1'b1;
                    ram_raddr = tgt_slot;
                    n_slot    = tgt_slot;
                end else begin
                    // head completes: hold its delivery and start the walk
                    n_pend_valid = r_item.has_receiver;
                    n_pend = '{status: STAT_DELIVER, out_seq_id: 16'(req_id),
                               out_receiver: r_item.receiver_handle,
                               out_content: r_item.content_handle, last: 1'b0};
                    n_released = CNT_BITS'(1);
                    n_slot     = head_inc;
                end
            end
            ST_CHECK: begin
                if (rd_slot.valid) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out = '{status: STAT_BADID, out_seq_id: 16'(req_id),
                                  out_receiver: '0, out_content: '0, last: 1'b1};
                    end
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = '{valid: 1'b1, has_receiver: r_item.has_receiver,
                                  receiver: r_item.receiver_handle,
                                  content: r_item.content_handle};
                end
            end
            ST_WALK_RD: begin
                ram_re = walk_more;
            end
            ST_WALK_EX: begin
                if (rd_slot.valid && !walk_hold) begin
                    // retire the slot, push the held delivery if a new one arrives
                    ram_we = 1'b1;
                    if (rd_slot.has_receiver) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out       = r_pend;
                        end
                        n_pend_valid = 1'b1;
                        n_pend = '{status: STAT_DELIVER, out_seq_id: 16'(walk_id),
                                   out_receiver: rd_slot.receiver,
                                   out_content: rd_slot.content, last: 1'b0};
                    end
                    n_released = r_released + 1'b1;
                    n_slot     = slot_inc;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out       = r_pend;
                        n_out.last  = 1'b1;
                    end
                    n_pend_valid = 1'b0;
                    n_oldest_id  = walk_id;
                    n_head       = r_slot;
                end
            end
            default: begin
                n_pend_valid = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_next_id    <= '0;
            r_oldest_id  <= '0;
            r_head       <= '0;
            r_slot       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_next_id    <= n_next_id;
            r_oldest_id  <= n_oldest_id;
            r_head       <= n_head;
            r_slot       <= n_slot;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_released <= n_released;
        r_pend     <= n_pend;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // checks
    `IORB_ASSERT(a_accept_decodes, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> (r_state == ST_DECODE), "accepted request did not reach decode")
    `IORB_ASSERT(a_window_bound, i_clk, i_rst_n, (out_cmp <= WINDOW_C), "outstanding ids exceed the window")
    `IORB_ASSERT(a_pend_in_walk, i_clk, i_rst_n, r_pend_valid |-> (r_state == ST_WALK_RD || r_state == ST_WALK_EX || r_state == ST_FLUSH), "held delivery outside a release walk")
    `IORB_ASSERT_NR(a_reset_clears, i_clk, (!i_rst_n) |=> (r_state == ST_CLEAR && !o_out_valid), "reset did not start the clearing pass")

endmodule
